// ----- rtl/core/rse_pkg.sv -----
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types, constants and GF(256) arithmetic for the Reed-Solomon encoder.
// ----------------------------------------------------------------------------
package rse_pkg;

    localparam int MAX_CHECK_BYTES_DEF = 32;
    localparam int ECC_W               = 6;
    localparam int ECC_RESET           = 13;
    localparam logic [8:0] GF_POLY     = 9'h11D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_end;
    } t_in;

    typedef struct packed {
        logic [7:0] check_byte;
        logic       check_last;
    } t_out;

    // Shift-and-add product in GF(256), reducing by the field polynomial.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] acc;
        x   = {1'b0, a};
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ x[7:0];
            end
            x = {x[7:0], 1'b0};
            if (x[8]) begin
                x = x ^ GF_POLY;
            end
        end
        return acc;
    endfunction

endpackage

// ----- rtl/core/reed_solomon_ecc_encoder_top.sv -----
// ----------------------------------------------------------------------------
// reed_solomon_ecc_encoder_top
// Systematic RS encoder over GF(256), polynomial 0x11D, roots alpha^0..n-1.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  -------   ---------  -------------------  -------------------------------
//  input     in         i_valid / o_ready    i_data : data_byte, block_end
//  output    out        o_valid / i_ready    o_data : check_byte, check_last
//  config    in         i_cfg_we             i_cfg_data : ecc_count (6 bit)
//
//  One data byte is taken per cycle while o_ready is high; the remainder update
//  is a combinational bank of parallel GF multiplies, one per check position.
//  A final byte waits while the generator builds and while the previous block's
//  check bytes still drain; the block's n check bytes leave at one per cycle
//  while i_ready is high, from a shift buffer. After reset and after each
//  ecc_count write the generator is rebuilt, one root per cycle; o_ready stays low meanwhile.
//  Reset is synchronous, active low; it clears the remainder and the drain
//  count and loads the reset ecc_count of 13, capped at MAX_CHECK_BYTES.
//
module reed_solomon_ecc_encoder_top #(
    parameter int MAX_CHECK_BYTES = rse_pkg::MAX_CHECK_BYTES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  rse_pkg::t_in              i_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output rse_pkg::t_out             o_data,
    input  logic                      i_cfg_we,
    input  logic [rse_pkg::ECC_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_CHECK_BYTES + 1);
    localparam int RST_EFF = (rse_pkg::ECC_RESET > MAX_CHECK_BYTES) ?
                             MAX_CHECK_BYTES : rse_pkg::ECC_RESET;

    // Remainder, entry 0 highest order; entries at or above n stay zero.
    logic [7:0]    r_rem   [MAX_CHECK_BYTES];
    logic [7:0]    n_rem   [MAX_CHECK_BYTES];
    // Generator coefficients g1..gn; entries above n are zero.
    logic [7:0]    r_gen   [MAX_CHECK_BYTES];
    logic [7:0]    n_gen   [MAX_CHECK_BYTES];
    logic [7:0]    r_root;
    logic [CW-1:0] r_build_cnt;
    logic [CW-1:0] r_eff;
    logic [CW-1:0] cfg_eff;
    // Check-byte drain buffer.
    logic [7:0]    r_out_buf [MAX_CHECK_BYTES];
    logic [CW-1:0] r_out_cnt;

    logic          in_acc;
    logic          out_acc;
    logic          buf_free;
    logic [7:0]    factor;

    // Saturate the written count into 1..MAX.
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_eff = CW'(1);
        end else if (int'(i_cfg_data) > MAX_CHECK_BYTES) begin
            cfg_eff = CW'(MAX_CHECK_BYTES);
        end else begin
            cfg_eff = CW'(i_cfg_data);
        end
    end

    // Accept data bytes while no build runs; hold a final byte until the drain buffer frees.
    assign buf_free = (r_out_cnt == '0) || ((r_out_cnt == CW'(1)) && i_ready);
    assign o_ready  = (r_build_cnt == '0) && (!i_data.block_end || buf_free);
    assign in_acc   = i_valid && o_ready;
    assign o_valid  = (r_out_cnt != '0);
    assign out_acc  = o_valid && i_ready;

    assign o_data.check_byte = r_out_buf[0];
    assign o_data.check_last = (r_out_cnt == CW'(1));

    // One division step: shift the remainder up and fold in factor * g.
    assign factor = i_data.data_byte ^ r_rem[0];
    always_comb begin
        for (int i = 0; i < MAX_CHECK_BYTES; i++) begin
            if (i + 1 < MAX_CHECK_BYTES) begin
                n_rem[i] = r_rem[i+1] ^ rse_pkg::gf_mul(r_gen[i], factor);
            end else begin
                n_rem[i] = rse_pkg::gf_mul(r_gen[i], factor);
            end
        end
    end

    // Generator build step: multiply the polynomial by (x + root).
    always_comb begin
        for (int k = 0; k < MAX_CHECK_BYTES; k++) begin
            if (k == 0) begin
                n_gen[k] = r_gen[k] ^ r_root;
            end else begin
                n_gen[k] = r_gen[k] ^ rse_pkg::gf_mul(r_gen[k-1], r_root);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff       <= CW'(RST_EFF);
            r_build_cnt <= CW'(RST_EFF);
            r_root      <= 8'h01;
            r_out_cnt   <= '0;
            for (int i = 0; i < MAX_CHECK_BYTES; i++) begin
                r_rem[i] <= 8'h00;
                r_gen[i] <= 8'h00;
            end
        end else if (i_cfg_we) begin
            // Restart the build and drop any partial block.
            r_eff       <= cfg_eff;
            r_build_cnt <= cfg_eff;
            r_root      <= 8'h01;
            for (int i = 0; i < MAX_CHECK_BYTES; i++) begin
                r_rem[i] <= 8'h00;
                r_gen[i] <= 8'h00;
            end
        end else begin
            if (r_build_cnt != '0) begin
                r_gen       <= n_gen;
                r_root      <= rse_pkg::gf_mul(r_root, 8'h02);
                r_build_cnt <= r_build_cnt - CW'(1);
            end
            if (in_acc) begin
                if (i_data.block_end) begin
                    for (int i = 0; i < MAX_CHECK_BYTES; i++) begin
                        r_rem[i] <= 8'h00;
                    end
                end else begin
                    r_rem <= n_rem;
                end
            end
            // Load wins over draining the last byte of the previous block.
            if (in_acc && i_data.block_end) begin
                r_out_cnt <= r_eff;
            end else if (out_acc) begin
                r_out_cnt <= r_out_cnt - CW'(1);
            end
        end
    end

    // Drain buffer payload: load on a final byte, advance on each accepted output byte.
    always_ff @(posedge i_clk) begin
        if (in_acc && i_data.block_end) begin
            r_out_buf <= n_rem;
        end else if (out_acc) begin
            for (int i = 0; i < MAX_CHECK_BYTES; i++) begin
                if (i + 1 < MAX_CHECK_BYTES) begin
                    r_out_buf[i] <= r_out_buf[i+1];
                end else begin
                    r_out_buf[i] <= 8'h00;
                end
            end
        end
    end

endmodule
